[hw/rtl/scml_pkg.sv]
// shared types and constants for the colormap lerp block
package scml_pkg;

   localparam int PALETTE_DEPTH = 16;
   localparam int IDX_W         = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 34;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PROD_W   = DIFF_W + SCALE_W;
   localparam int FRAC_W   = 16;
   localparam int T_W      = FRAC_W + 1;
   localparam int POS_W    = T_W + CNT_W;
   localparam int COLOR_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = COLOR_W / CHAN_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [1:0] REG_RANGE_MIN   = 2'd0;
   localparam logic [1:0] REG_SCALE       = 2'd1;
   localparam logic [1:0] REG_STRONG_MODE = 2'd2;
   localparam logic [1:0] REG_COLOR_COUNT = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_MAP  = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [3:0]                 entry_index;
      logic [COLOR_W-1:0]         entry_color;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] range_min;
      logic signed [SCALE_W-1:0]  scale;
      logic                       strong_mode;
      logic [4:0]                 color_count;
   } cfg_type;

   typedef struct packed {
      logic               map;
      logic               load;
      logic               white;
      logic [IDX_W-1:0]   idx0;
      logic [IDX_W-1:0]   idx1;
      logic [FRAC_W-1:0]  frac;
      logic [IDX_W-1:0]   wr_addr;
      logic [COLOR_W-1:0] wr_data;
   } lookup_type;

endpackage

[hw/rtl/scml_position.sv]
// position pipeline: offset, scale multiply, clamp, palette index and fraction
module scml_position (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  scml_pkg::req_type    req,
   input  scml_pkg::cfg_type    cfg,
   output scml_pkg::lookup_type lookup
);

   typedef struct packed {
      logic                          map;
      logic                          load;
      logic [scml_pkg::IDX_W-1:0]    wr_addr;
      logic [scml_pkg::COLOR_W-1:0]  wr_data;
   } tag_type;

   tag_type                                s1_tag_ff, s1_tag_in;
   logic signed [scml_pkg::DIFF_W-1:0]     s1_diff_ff, s1_diff_in;
   tag_type                                s2_tag_ff;
   logic signed [scml_pkg::PROD_W-1:0]     s2_prod_ff, s2_prod_in;
   tag_type                                s3_tag_ff;
   logic [scml_pkg::T_W-1:0]               s3_t_ff, s3_t_in;
   logic                                   s3_nonpos_ff, s3_nonpos_in;
   scml_pkg::lookup_type                   s4_ff, s4_in;

   logic [scml_pkg::CNT_W-1:0]             count;
   logic [scml_pkg::CNT_W:0]               cm1;
   logic [scml_pkg::CNT_W:0]               cm2;
   logic [scml_pkg::CNT_W:0]               mult;
   logic [scml_pkg::POS_W-1:0]             pos;
   logic [scml_pkg::CNT_W:0]               hi;
   logic [scml_pkg::CNT_W:0]               i0;
   logic [scml_pkg::CNT_W:0]               i0p1;
   logic [scml_pkg::CNT_W:0]               i1;
   logic                                   force0;

   // stage 1: offset from range minimum
   always_comb begin
      s1_tag_in.map     = accept && (req.kind == scml_pkg::KIND_MAP);
      s1_tag_in.load    = accept && (req.kind == scml_pkg::KIND_LOAD)
                          && (32'(req.entry_index) < scml_pkg::PALETTE_DEPTH);
      s1_tag_in.wr_addr = scml_pkg::IDX_W'(req.entry_index);
      s1_tag_in.wr_data = req.entry_color;
      s1_diff_in = $signed({req.sample[scml_pkg::SAMPLE_W-1], req.sample})
                 - $signed({cfg.range_min[scml_pkg::SAMPLE_W-1], cfg.range_min});
   end

   // stage 2: scale multiply
   always_comb begin
      s2_prod_in = scml_pkg::PROD_W'(s1_diff_ff) * scml_pkg::PROD_W'(cfg.scale);
   end

   // stage 3: clamp to 0..1.0 in q16
   always_comb begin
      s3_nonpos_in = s2_prod_ff[scml_pkg::PROD_W-1]
                  || (s2_prod_ff[scml_pkg::PROD_W-2:scml_pkg::FRAC_W] == '0);
      if (s2_prod_ff[scml_pkg::PROD_W-1]) begin
         s3_t_in = '0;
      end else if (s2_prod_ff[scml_pkg::PROD_W-2:scml_pkg::FRAC_W]
                   > (scml_pkg::PROD_W-1-scml_pkg::FRAC_W)'(1 << scml_pkg::FRAC_W)) begin
         s3_t_in = scml_pkg::T_W'(1 << scml_pkg::FRAC_W);
      end else begin
         s3_t_in = s2_prod_ff[scml_pkg::FRAC_W+scml_pkg::T_W-1:scml_pkg::FRAC_W];
      end
   end

   // stage 4: palette position, neighbor indexes and fraction
   always_comb begin
      if (32'(cfg.color_count) > scml_pkg::PALETTE_DEPTH) begin
         count = scml_pkg::CNT_W'(scml_pkg::PALETTE_DEPTH);
      end else begin
         count = scml_pkg::CNT_W'(cfg.color_count);
      end
      cm1  = {1'b0, count} - (scml_pkg::CNT_W+1)'(1);
      cm2  = {1'b0, count} - (scml_pkg::CNT_W+1)'(2);
      mult = cfg.strong_mode ? cm2 : cm1;
      pos  = scml_pkg::POS_W'(s3_t_ff) * scml_pkg::POS_W'(mult)
           + (cfg.strong_mode ? scml_pkg::POS_W'(1 << scml_pkg::FRAC_W) : '0);
      hi   = pos[scml_pkg::POS_W-1:scml_pkg::FRAC_W];
      i0   = (hi > cm1) ? cm1 : hi;
      i0p1 = i0 + (scml_pkg::CNT_W+1)'(1);
      i1   = (i0p1 > cm1) ? cm1 : i0p1;
      force0 = (count <= scml_pkg::CNT_W'(1)) || (cfg.strong_mode && s3_nonpos_ff);

      s4_in.map     = s3_tag_ff.map;
      s4_in.load    = s3_tag_ff.load;
      s4_in.white   = (count == '0);
      s4_in.wr_addr = s3_tag_ff.wr_addr;
      s4_in.wr_data = s3_tag_ff.wr_data;
      if (force0) begin
         s4_in.idx0 = '0;
         s4_in.idx1 = '0;
         s4_in.frac = '0;
      end else begin
         s4_in.idx0 = scml_pkg::IDX_W'(i0);
         s4_in.idx1 = scml_pkg::IDX_W'(i1);
         s4_in.frac = pos[scml_pkg::FRAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_diff_ff   <= s1_diff_in;
      s2_prod_ff   <= s2_prod_in;
      s3_t_ff      <= s3_t_in;
      s3_nonpos_ff <= s3_nonpos_in;
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_ff     <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_ff     <= s4_in;
      end
   end

   assign lookup = s4_ff;

endmodule

[hw/rtl/scml_palette.sv]
// palette memory: one write port, two registered read ports
module scml_palette (
   input  logic                          clock,
   input  scml_pkg::lookup_type          lookup,
   output logic [scml_pkg::COLOR_W-1:0]  rd0_data,
   output logic [scml_pkg::COLOR_W-1:0]  rd1_data
);

   logic [scml_pkg::COLOR_W-1:0] palette_ff [scml_pkg::PALETTE_DEPTH];
   logic [scml_pkg::COLOR_W-1:0] rd0_ff;
   logic [scml_pkg::COLOR_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (lookup.load) begin
         palette_ff[lookup.wr_addr] <= lookup.wr_data;
      end
      rd0_ff <= palette_ff[lookup.idx0];
      rd1_ff <= palette_ff[lookup.idx1];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

[hw/rtl/scml_blend.sv]
// per-channel blend of the two neighbor entries and result register
module scml_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  scml_pkg::lookup_type          lookup,
   input  logic [scml_pkg::COLOR_W-1:0]  rd0_data,
   input  logic [scml_pkg::COLOR_W-1:0]  rd1_data,
   output logic                          rsp_valid,
   output scml_pkg::rsp_type             rsp_data
);

   localparam int ACC_W = scml_pkg::CHAN_W + scml_pkg::T_W + 1;

   logic                          s5_valid_ff;
   logic                          s5_white_ff;
   logic [scml_pkg::FRAC_W-1:0]   s5_frac_ff;
   logic                          rsp_valid_ff;
   scml_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [scml_pkg::T_W-1:0]      inv_frac;
   logic [ACC_W-1:0]              acc [scml_pkg::NUM_CHAN];
   logic [scml_pkg::COLOR_W-1:0]  mixed;

   always_comb begin
      inv_frac = scml_pkg::T_W'(1 << scml_pkg::FRAC_W) - scml_pkg::T_W'(s5_frac_ff);
      for (int ch = 0; ch < scml_pkg::NUM_CHAN; ch++) begin
         acc[ch] = ACC_W'(rd0_data[ch*scml_pkg::CHAN_W +: scml_pkg::CHAN_W]) * ACC_W'(inv_frac)
                 + ACC_W'(rd1_data[ch*scml_pkg::CHAN_W +: scml_pkg::CHAN_W])
                   * ACC_W'(s5_frac_ff)
                 + ACC_W'(1 << (scml_pkg::FRAC_W - 1));
         mixed[ch*scml_pkg::CHAN_W +: scml_pkg::CHAN_W] =
            acc[ch][scml_pkg::FRAC_W +: scml_pkg::CHAN_W];
      end
      if (s5_white_ff) begin
         rsp_data_in = '1;
      end else begin
         rsp_data_in = mixed;
      end
   end

   always_ff @(posedge clock) begin
      s5_white_ff <= lookup.white;
      s5_frac_ff  <= lookup.frac;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= lookup.map;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/sequential_colormap_lerp_top.sv]
// top level: register port, position pipeline, palette memory and blend
//
// Maps signed 16-bit samples to RGBA8 colors by linear interpolation over a
// palette of up to 16 entries. One item is taken on every clock (busy stays
// low); a map item gives its color on rsp_valid once it has passed the
// pipeline stages below, a load item writes its palette slot and gives no
// result. The stages are offset, the 17x34 scale multiply, clamp, index
// and fraction, palette read, and the channel blend. A palette write is
// seen by the very next item. Results cannot be held off and must be taken
// in the cycle they appear. Registers are 64 bits wide at byte addresses
// 0x00 range_min, 0x08 scale, 0x10 strong_mode, 0x18 color_count, and must
// be written only while no item is in flight; the block does not enforce it.
module sequential_colormap_lerp_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  scml_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output scml_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scml_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [scml_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [scml_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic signed [scml_pkg::SAMPLE_W-1:0] range_min_ff;
   logic signed [scml_pkg::SCALE_W-1:0]  scale_ff;
   logic                                 strong_mode_ff;
   logic [4:0]                           color_count_ff;

   logic                                 csr_write;
   logic [1:0]                           csr_index;
   scml_pkg::cfg_type                    cfg;
   scml_pkg::lookup_type                 lookup;
   logic [scml_pkg::COLOR_W-1:0]         rd0_data;
   logic [scml_pkg::COLOR_W-1:0]         rd1_data;

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[scml_pkg::CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff   <= '0;
         scale_ff       <= scml_pkg::SCALE_W'(1 << scml_pkg::FRAC_W);
         strong_mode_ff <= 1'b0;
         color_count_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            scml_pkg::REG_RANGE_MIN: begin
               range_min_ff <= pwdata[scml_pkg::SAMPLE_W-1:0];
            end
            scml_pkg::REG_SCALE: begin
               scale_ff <= pwdata[scml_pkg::SCALE_W-1:0];
            end
            scml_pkg::REG_STRONG_MODE: begin
               strong_mode_ff <= pwdata[0];
            end
            scml_pkg::REG_COLOR_COUNT: begin
               color_count_ff <= pwdata[4:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         scml_pkg::REG_RANGE_MIN: begin
            prdata = {{(scml_pkg::CSR_DATA_W-scml_pkg::SAMPLE_W){range_min_ff[15]}},
                      range_min_ff};
         end
         scml_pkg::REG_SCALE: begin
            prdata = {{(scml_pkg::CSR_DATA_W-scml_pkg::SCALE_W){scale_ff[33]}}, scale_ff};
         end
         scml_pkg::REG_STRONG_MODE: begin
            prdata = scml_pkg::CSR_DATA_W'(strong_mode_ff);
         end
         scml_pkg::REG_COLOR_COUNT: begin
            prdata = scml_pkg::CSR_DATA_W'(color_count_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.range_min   = range_min_ff;
   assign cfg.scale       = scale_ff;
   assign cfg.strong_mode = strong_mode_ff;
   assign cfg.color_count = color_count_ff;

   scml_position u_position (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy),
      .req    (req_data),
      .cfg    (cfg),
      .lookup (lookup)
   );

   scml_palette u_palette (
      .clock    (clock),
      .lookup   (lookup),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   scml_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .lookup    (lookup),
      .rd0_data  (rd0_data),
      .rd1_data  (rd1_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/scml_checker.sv]
// port-level checks for the colormap lerp block and their binding
module scml_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input scml_pkg::req_type req_data,
   input logic              rsp_valid
);

   localparam int LATENCY = 6;

   a_map_gives_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.kind == scml_pkg::KIND_MAP) |-> ##LATENCY rsp_valid)
      else $error("map item gave no result");

   a_load_is_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.kind == scml_pkg::KIND_LOAD) |-> ##LATENCY !rsp_valid)
      else $error("load item gave a result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_data.kind == scml_pkg::KIND_MAP), LATENCY))
      else $error("result without a map item");

endmodule

bind sequential_colormap_lerp_top scml_port_checks u_scml_port_checks (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid)
);

[bench/scml_checker.sv]
// checker for the colormap lerp block: watches item, result and register ports, predicts colors
`timescale 1ns / 1ps

module scml_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  scml_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  scml_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [scml_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [scml_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int                              mismatches,
   output int                              pending
);

   localparam longint ONE_Q16  = 65536;
   localparam longint HALF_Q16 = 32768;

   scml_pkg::cfg_type            cfg;
   logic [scml_pkg::COLOR_W-1:0] palette_copy [scml_pkg::PALETTE_DEPTH];
   scml_pkg::rsp_type            expected_colors [$];

   function automatic scml_pkg::rsp_type lookup_color(
      input logic signed [scml_pkg::SAMPLE_W-1:0] sample);
      longint                       cnt, diff, prod, t, pos, i0, i1, f, a, b, v;
      logic [scml_pkg::COLOR_W-1:0] c0, c1, mix;
      cnt = longint'(cfg.color_count);
      if (cnt > scml_pkg::PALETTE_DEPTH) cnt = scml_pkg::PALETTE_DEPTH;
      if (cnt == 0) return '1;
      if (cnt == 1) return scml_pkg::rsp_type'(palette_copy[0]);
      diff = longint'(sample) - longint'($signed(cfg.range_min));
      prod = diff * longint'($signed(cfg.scale));
      if (prod < 0) begin
         t = 0;
      end else begin
         t = prod >>> scml_pkg::FRAC_W;
         if (t > ONE_Q16) t = ONE_Q16;
      end
      if (cfg.strong_mode) begin
         // a scaled offset that clamps to zero keeps the reserved first entry
         if (prod < ONE_Q16) return scml_pkg::rsp_type'(palette_copy[0]);
         pos = ONE_Q16 + t * (cnt - 2);
      end else begin
         pos = t * (cnt - 1);
      end
      i0 = pos >>> scml_pkg::FRAC_W;
      if (i0 > cnt - 1) i0 = cnt - 1;
      i1 = i0 + 1;
      if (i1 > cnt - 1) i1 = cnt - 1;
      f = pos & (ONE_Q16 - 1);
      c0 = palette_copy[i0];
      c1 = palette_copy[i1];
      for (int k = 0; k < scml_pkg::NUM_CHAN; k++) begin
         a = longint'(c0[k*scml_pkg::CHAN_W +: scml_pkg::CHAN_W]);
         b = longint'(c1[k*scml_pkg::CHAN_W +: scml_pkg::CHAN_W]);
         v = (a * (ONE_Q16 - f) + b * f + HALF_Q16) >>> scml_pkg::FRAC_W;
         mix[k*scml_pkg::CHAN_W +: scml_pkg::CHAN_W] = v[scml_pkg::CHAN_W-1:0];
      end
      return scml_pkg::rsp_type'(mix);
   endfunction

   always @(posedge clock) begin
      scml_pkg::rsp_type want;
      if (reset) begin
         cfg.range_min   = '0;
         cfg.scale       = 34'sd65536;
         cfg.strong_mode = 1'b0;
         cfg.color_count = '0;
         foreach (palette_copy[i]) palette_copy[i] = '0;
         expected_colors.delete();
         mismatches = 0;
         pending    = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_colors.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected color %h", rsp_data);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue || rsp_data.alpha !== want.alpha) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("color mismatch: expected %h actual %h", want, rsp_data);
               end
            end
         end
         if (start && !busy) begin
            if (req_data.kind == scml_pkg::KIND_LOAD) begin
               palette_copy[req_data.entry_index] = req_data.entry_color;
            end else begin
               expected_colors = {expected_colors, lookup_color(req_data.sample)};
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               scml_pkg::REG_RANGE_MIN:
                  cfg.range_min = pwdata[scml_pkg::SAMPLE_W-1:0];
               scml_pkg::REG_SCALE:
                  cfg.scale = pwdata[scml_pkg::SCALE_W-1:0];
               scml_pkg::REG_STRONG_MODE:
                  cfg.strong_mode = pwdata[0];
               scml_pkg::REG_COLOR_COUNT:
                  cfg.color_count = pwdata[4:0];
               default: ;
            endcase
         end
         pending = expected_colors.size();
      end
   end

endmodule

[bench/tb_sequential_colormap_lerp_top.sv]
// testbench top for the colormap lerp block: clock, reset, item and register stimulus, verdict
`timescale 1ns / 1ps

module tb_sequential_colormap_lerp_top;

   localparam int     LIMIT_CYCLES    = 400000;
   localparam int     SETTLE_CYCLES   = 10;
   localparam int     NUM_PHASES      = 12;
   localparam int     ITEMS_PER_PHASE = 94;
   localparam longint SPAN_Q32        = 64'h1_0000_0000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start;
   logic                            busy;
   scml_pkg::req_type               req_data;
   logic                            rsp_valid;
   scml_pkg::rsp_type               rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [scml_pkg::CSR_ADDR_W-1:0] paddr;
   logic [scml_pkg::CSR_DATA_W-1:0] pwdata;
   logic [scml_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;
   int                              mismatches;
   int                              pending;
   bit                              no_idle;

   always #1 clock = ~clock;

   sequential_colormap_lerp_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   scml_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .pending    (pending)
   );

   task automatic send_item(input scml_pkg::req_type item);
      int r, n;
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) n = 0;
      else if (r < 88) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(20, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_map(input logic [scml_pkg::SAMPLE_W-1:0] sample);
      scml_pkg::req_type item;
      item.kind        = scml_pkg::KIND_MAP;
      item.sample      = sample;
      item.entry_index = 4'($urandom_range(0, 15));
      item.entry_color = $urandom();
      send_item(item);
   endtask

   task automatic send_load(input logic [3:0] idx,
                            input logic [scml_pkg::COLOR_W-1:0] color);
      scml_pkg::req_type item;
      item.kind        = scml_pkg::KIND_LOAD;
      item.sample      = 16'($urandom());
      item.entry_index = idx;
      item.entry_color = color;
      send_item(item);
   endtask

   // hold off until every color is back and loads have drained
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] which,
                            input logic [scml_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input logic signed [scml_pkg::SAMPLE_W-1:0] rmin,
                            input logic signed [scml_pkg::SCALE_W-1:0] scl,
                            input logic strong_en, input logic [4:0] cnt);
      settle();
      csr_write(scml_pkg::REG_RANGE_MIN,
                {{(scml_pkg::CSR_DATA_W-scml_pkg::SAMPLE_W){rmin[scml_pkg::SAMPLE_W-1]}},
                 rmin});
      csr_write(scml_pkg::REG_SCALE,
                {{(scml_pkg::CSR_DATA_W-scml_pkg::SCALE_W){scl[scml_pkg::SCALE_W-1]}}, scl});
      csr_write(scml_pkg::REG_STRONG_MODE, scml_pkg::CSR_DATA_W'(strong_en));
      csr_write(scml_pkg::REG_COLOR_COUNT, scml_pkg::CSR_DATA_W'(cnt));
   endtask

   initial begin : watchdog
      for (int n = 0; n < LIMIT_CYCLES; n++) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic signed [scml_pkg::SAMPLE_W-1:0] rmin;
      logic signed [scml_pkg::SCALE_W-1:0]  scl;
      logic                                 strong_en;
      logic [4:0]                           cnt;
      longint                               span, mag;
      int                                   dir, off;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      no_idle  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty palette right after reset gives white
      send_map(16'sd0);
      send_load(4'd0, 32'h0000_0000);
      send_load(4'd1, 32'hFF00_FF00);
      send_load(4'd2, 32'h00FF_00FF);
      for (int i = 3; i < 15; i++) send_load(4'(i), $urandom());
      send_load(4'd15, 32'hFFFF_FFFF);

      // single entry
      configure(16'sd0, 34'sd65536, 1'b0, 5'd1);
      send_map(16'sh7FFF);
      configure(-16'sd32768, 34'sd65536, 1'b0, 5'd16);
      send_map(16'sh8000);
      send_map(16'sh7FFF);
      send_map(16'sd0);
      // strong mode around the minimum
      configure(-16'sd32768, 34'sd65536, 1'b1, 5'd16);
      send_map(16'sh8000);
      send_map(16'sh8001);
      send_map(16'sh7FFF);
      // count above depth, full-range clamp
      configure(-16'sd32768, 34'sh1_0000_0000, 1'b0, 5'd31);
      send_map(16'sh8000);
      send_map(16'sh8001);

      for (int p = 0; p < NUM_PHASES; p++) begin
         rmin      = 16'($urandom());
         span      = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 65535)) :
                                                   longint'($urandom_range(1, 600));
         scl       = scml_pkg::SCALE_W'(SPAN_Q32 / span);
         strong_en = 1'($urandom_range(0, 1));
         cnt       = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                                   5'($urandom_range(2, 16));
         if ($urandom_range(0, 4) == 0) begin
            mag = longint'($urandom()) + longint'($urandom_range(0, 1));
            scl = scml_pkg::SCALE_W'($urandom_range(0, 1) ? -mag : mag);
         end
         case (p)
            0: begin
               rmin = 16'sh7FFF; scl = -34'sh1_0000_0000; strong_en = 1'b1; cnt = 5'd2;
            end
            1: cnt = 5'd0;
            2: begin
               rmin = 16'sh8000; scl = 34'sh1_0000_0000; strong_en = 1'b0; cnt = 5'd16;
            end
            3: begin
               rmin = 16'sd0; scl = 34'sd1; strong_en = 1'b1; cnt = 5'd17;
            end
            4: cnt = 5'd31;
            5: scl = 34'sd0;
            default: ;
         endcase
         dir     = (scl < 0) ? -1 : 1;
         no_idle = (p % 4 == 3);
         configure(rmin, scl, strong_en, cnt);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 6 && n == ITEMS_PER_PHASE / 2) settle();
            if ($urandom_range(0, 99) < 15) begin
               send_load(4'($urandom_range(0, 15)), $urandom());
            end else if ($urandom_range(0, 9) < 7) begin
               off = int'($urandom_range(0, 32'(span + span / 8))) - int'(span / 16);
               send_map(16'(int'(rmin) + dir * off));
            end else begin
               send_map(16'($urandom()));
            end
         end
      end

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/scml_pkg.sv
hw/rtl/scml_position.sv
hw/rtl/scml_palette.sv
hw/rtl/scml_blend.sv
hw/rtl/sequential_colormap_lerp_top.sv
hw/rtl/scml_checker.sv
bench/scml_checker.sv
bench/tb_sequential_colormap_lerp_top.sv
